// File: hw/rtl/blsc_pkg.sv
// Shared constants, tables and pipeline record types for the bond length and stiffness core.
`default_nettype none

package blsc_pkg;

  // Magnitude of ln(n/4) in Q16 for bond orders n = 0..31. The log is negative below four.
  localparam logic [17:0] LN_MAG [32] = '{
    18'd0,      18'd90852,  18'd45426,  18'd18854,  18'd0,      18'd14624,  18'd26573,  18'd36675,
    18'd45426,  18'd53145,  18'd60050,  18'd66296,  18'd71999,  18'd77244,  18'd82101,  18'd86623,
    18'd90852,  18'd94825,  18'd98571,  18'd102115, 18'd105476, 18'd108674, 18'd111722, 18'd114636,
    18'd117425, 18'd120100, 18'd122670, 18'd125144, 18'd127527, 18'd129827, 18'd132049, 18'd134198
  };

  localparam logic [4:0]  ORDER_ONE = 5'd4;        // order 1.0 in quarter units
  localparam logic [13:0] K_ORDER   = 14'd8729;    // 0.1332 in Q16
  localparam logic [25:0] K_STIFF   = 26'd42213048; // 644.12 in Q16
  localparam logic [19:0] LEN_MAX   = 20'hFFFFF;
  localparam int unsigned KQ_BITS   = 31;          // stiffness quotient bits below saturation

  // Record carried alongside the square root unit.
  typedef struct packed {
    logic [15:0]        da;
    logic [15:0]        db;
    logic [31:0]        rarb;
    logic [32:0]        den;
    logic [16:0]        rsum;
    logic signed [63:0] rbo;
    logic [56:0]        n;
    logic               neg;
  } sq_side_t;

  // Record carried alongside the length divider.
  typedef struct packed {
    logic [16:0]        rsum;
    logic signed [63:0] rbo;
    logic [56:0]        n;
    logic               neg;
    logic               den_zero;
  } len_side_t;

  // Record carried alongside the stiffness divider.
  typedef struct packed {
    logic [19:0] len;
    logic        sat;
    logic        ksat;
    logic        neg;
    logic        inv;
  } stf_side_t;

endpackage

`default_nettype wire

// File: hw/rtl/bond_length_and_stiffness_core.sv
// Top level of the bond length and stiffness pipeline.
`default_nettype none

// Takes one atom pair per cycle; busy_o never rises. Each pair gives one result
// on valid_o after the 16-stage square root, the length divider with 81 - FRAC_BITS
// stages, the 31-stage stiffness divider and eleven arithmetic stages. Results cannot be
// held off: a result is present for one cycle only and must be taken then.
module bond_length_and_stiffness_core #(
  parameter int unsigned FRAC_BITS = 13
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [15:0]        radius_a_i,
  input  wire logic [15:0]        radius_b_i,
  input  wire logic [15:0]        distance_a_i,
  input  wire logic [15:0]        distance_b_i,
  input  wire logic signed [15:0] charge_a_i,
  input  wire logic signed [15:0] charge_b_i,
  input  wire logic [4:0]         bond_order_i,
  output logic                    valid_o,
  output logic [19:0]             bond_length_o,
  output logic signed [31:0]      bond_stiffness_o,
  output logic                    saturated_o,
  output logic                    invalid_o
);

  localparam int unsigned SH   = 32 - FRAC_BITS;   // shift from input scale to Q32
  localparam int unsigned NW   = 49 + SH;          // length dividend width
  localparam int unsigned SQSW = $bits(blsc_pkg::sq_side_t);
  localparam int unsigned LSW  = $bits(blsc_pkg::len_side_t);
  localparam int unsigned KSW  = $bits(blsc_pkg::stf_side_t);
  localparam logic [49:0] HALF = 50'(1) << (FRAC_BITS - 1);

  assign busy_o = 1'b0;

  // Stage 1: products straight from the ports.
  logic               s1_valid_q;
  logic [31:0]        s1_rarb_q, s1_dadb_q, s1_dara_q, s1_dbrb_q, s1_lnk_q;
  logic [16:0]        s1_rsum_q;
  logic               s1_lnpos_q;
  logic signed [31:0] s1_prod_q;
  logic [15:0]        s1_da_q, s1_db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_rarb_q  <= radius_a_i * radius_b_i;
    s1_dadb_q  <= distance_a_i * distance_b_i;
    s1_dara_q  <= distance_a_i * radius_a_i;
    s1_dbrb_q  <= distance_b_i * radius_b_i;
    s1_rsum_q  <= {1'b0, radius_a_i} + {1'b0, radius_b_i};
    s1_lnk_q   <= blsc_pkg::LN_MAG[bond_order_i] * blsc_pkg::K_ORDER;
    s1_lnpos_q <= bond_order_i > blsc_pkg::ORDER_ONE;
    s1_prod_q  <= charge_a_i * charge_b_i;
    s1_da_q    <= distance_a_i;
    s1_db_q    <= distance_b_i;
  end

  // Stage 2: denominator, order term magnitude, charge product magnitude.
  logic        s2_valid_q;
  logic [32:0] s2_den_q;
  logic [48:0] s2_mag_q;
  logic [30:0] s2_pmag_q;
  logic        s2_neg_q, s2_lnpos_q;
  logic [31:0] s2_rarb_q, s2_dadb_q;
  logic [16:0] s2_rsum_q;
  logic [15:0] s2_da_q, s2_db_q;
  logic [31:0] s2_pabs;

  assign s2_pabs = s1_prod_q[31] ? (32'd0 - s1_prod_q) : s1_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_den_q   <= {1'b0, s1_dara_q} + {1'b0, s1_dbrb_q};
    s2_mag_q   <= s1_lnk_q * s1_rsum_q;
    s2_pmag_q  <= s2_pabs[30:0];
    s2_neg_q   <= s1_prod_q[31];
    s2_lnpos_q <= s1_lnpos_q;
    s2_rarb_q  <= s1_rarb_q;
    s2_dadb_q  <= s1_dadb_q;
    s2_rsum_q  <= s1_rsum_q;
    s2_da_q    <= s1_da_q;
    s2_db_q    <= s1_db_q;
  end

  // Stage 3: round the order term to Q32 and scale the charge product.
  logic                 s3_valid_q;
  logic [31:0]          s3_dadb_q;
  blsc_pkg::sq_side_t   s3_side_q;
  logic [49:0]          s3_rnd;
  logic [63:0]          s3_rmag;

  assign s3_rnd  = ({1'b0, s2_mag_q} + HALF) >> FRAC_BITS;
  assign s3_rmag = 64'(s3_rnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_dadb_q      <= s2_dadb_q;
    s3_side_q.da   <= s2_da_q;
    s3_side_q.db   <= s2_db_q;
    s3_side_q.rarb <= s2_rarb_q;
    s3_side_q.den  <= s2_den_q;
    s3_side_q.rsum <= s2_rsum_q;
    s3_side_q.rbo  <= s2_lnpos_q ? (64'sd0 - $signed(s3_rmag)) : $signed(s3_rmag);
    s3_side_q.n    <= s2_pmag_q * blsc_pkg::K_STIFF;
    s3_side_q.neg  <= s2_neg_q;
  end

  // Square root of da*db.
  logic               sq_valid;
  logic [15:0]        sq_root;
  logic [SQSW-1:0]    sq_side_raw;
  blsc_pkg::sq_side_t sq_side;

  blsc_isqrt #(.SW(SQSW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid_q),
    .value_i (s3_dadb_q),
    .side_i  (s3_side_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side_raw)
  );

  assign sq_side = blsc_pkg::sq_side_t'(sq_side_raw);

  // Stage 4: squared difference of the root terms.
  logic               s4_valid_q;
  logic [16:0]        s4_diff2_q;
  blsc_pkg::sq_side_t s4_side_q;
  logic [17:0]        s4_diff2;

  assign s4_diff2 = {2'b00, sq_side.da} + {2'b00, sq_side.db} - {1'b0, sq_root, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_diff2_q <= s4_diff2[16:0];
    s4_side_q  <= sq_side;
  end

  // Stage 5: numerator of the electronegativity term.
  logic                s5_valid_q;
  logic [48:0]         s5_num_q;
  logic [32:0]         s5_den_q;
  blsc_pkg::len_side_t s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_num_q           <= s4_side_q.rarb * s4_diff2_q;
    s5_den_q           <= s4_side_q.den;
    s5_side_q.rsum     <= s4_side_q.rsum;
    s5_side_q.rbo      <= s4_side_q.rbo;
    s5_side_q.n        <= s4_side_q.n;
    s5_side_q.neg      <= s4_side_q.neg;
    s5_side_q.den_zero <= s4_side_q.den == '0;
  end

  // Length divider: floor(num * 2^SH / den), kept modulo 2^64.
  logic                dv_valid;
  logic [NW-1:0]       dv_quot;
  logic [LSW-1:0]      dv_side_raw;
  blsc_pkg::len_side_t dv_side;

  blsc_div #(.DW(33), .QW(NW), .SW(LSW)) u_len_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s5_valid_q),
    .rem_i     (33'd0),
    .bits_i    ({s5_num_q, {SH{1'b0}}}),
    .divisor_i (s5_den_q),
    .side_i    (s5_side_q),
    .valid_o   (dv_valid),
    .quot_o    (dv_quot),
    .side_o    (dv_side_raw)
  );

  assign dv_side = blsc_pkg::len_side_t'(dv_side_raw);

  // Stage 6: Q32 sum of all length terms.
  logic               s6_valid_q;
  logic signed [63:0] s6_total_q;
  logic [56:0]        s6_n_q;
  logic               s6_neg_q, s6_dz_q;
  logic [63:0]        s6_base;

  assign s6_base = 64'(dv_side.rsum) << SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else begin
      s6_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_total_q <= $signed(s6_base) + dv_side.rbo + $signed(64'(dv_quot));
    s6_n_q     <= dv_side.n;
    s6_neg_q   <= dv_side.neg;
    s6_dz_q    <= dv_side.den_zero;
  end

  // Stage 7: round to Q16 and clip the length.
  logic        s7_valid_q;
  logic [19:0] s7_len_q;
  logic        s7_sat_q, s7_inv_q, s7_neg_q;
  logic [56:0] s7_n_q;
  logic [63:0] s7_rnd;
  logic [47:0] s7_lenw;
  logic [19:0] s7_len;
  logic        s7_sat;

  assign s7_rnd  = 64'(s6_total_q) + 64'd32768;
  assign s7_lenw = s7_rnd[63:16];

  always_comb begin
    if (s6_total_q[63]) begin
      s7_len = '0;
      s7_sat = 1'b1;
    end else if (s7_lenw > 48'(blsc_pkg::LEN_MAX)) begin
      s7_len = blsc_pkg::LEN_MAX;
      s7_sat = 1'b1;
    end else begin
      s7_len = s7_lenw[19:0];
      s7_sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else begin
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_len_q <= s7_len;
    s7_sat_q <= s7_sat;
    s7_inv_q <= s6_dz_q || (s7_len == '0);
    s7_neg_q <= s6_neg_q;
    s7_n_q   <= s6_n_q;
  end

  // Stages 8 and 9: cube of the length.
  logic        s8_valid_q, s9_valid_q;
  logic [39:0] s8_len2_q;
  logic [59:0] s9_d_q;
  logic [19:0] s8_len_q, s9_len_q;
  logic        s8_sat_q, s8_inv_q, s8_neg_q, s9_sat_q, s9_inv_q, s9_neg_q;
  logic [56:0] s8_n_q, s9_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_valid_q <= 1'b0;
      s9_valid_q <= 1'b0;
    end else begin
      s8_valid_q <= s7_valid_q;
      s9_valid_q <= s8_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s8_len2_q <= s7_len_q * s7_len_q;
    s8_len_q  <= s7_len_q;
    s8_sat_q  <= s7_sat_q;
    s8_inv_q  <= s7_inv_q;
    s8_neg_q  <= s7_neg_q;
    s8_n_q    <= s7_n_q;
    s9_d_q    <= s8_len2_q * s8_len_q;
    s9_len_q  <= s8_len_q;
    s9_sat_q  <= s8_sat_q;
    s9_inv_q  <= s8_inv_q;
    s9_neg_q  <= s8_neg_q;
    s9_n_q    <= s8_n_q;
  end

  // Stage 10: overflow test and divider setup. Below saturation the quotient has 31 bits,
  // so the top of the scaled dividend is already a valid partial remainder.
  logic                s10_valid_q;
  logic [59:0]         s10_rem_q, s10_d_q;
  logic [30:0]         s10_bits_q;
  blsc_pkg::stf_side_t s10_side_q;
  logic                s10_ksat;

  assign s10_ksat = {10'd0, s9_n_q} >= {s9_d_q, 7'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_valid_q <= 1'b0;
    end else begin
      s10_valid_q <= s9_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s10_rem_q       <= s10_ksat ? 60'd0 : 60'(s9_n_q[56:7]);
    s10_bits_q      <= {s9_n_q[6:0], 24'd0};
    s10_d_q         <= s9_d_q;
    s10_side_q.len  <= s9_len_q;
    s10_side_q.sat  <= s9_sat_q;
    s10_side_q.ksat <= s10_ksat;
    s10_side_q.neg  <= s9_neg_q;
    s10_side_q.inv  <= s9_inv_q;
  end

  logic                           kd_valid;
  logic [blsc_pkg::KQ_BITS-1:0]   kd_quot;
  logic [KSW-1:0]                 kd_side_raw;
  blsc_pkg::stf_side_t            kd_side;

  blsc_div #(.DW(60), .QW(blsc_pkg::KQ_BITS), .SW(KSW)) u_stf_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s10_valid_q),
    .rem_i     (s10_rem_q),
    .bits_i    (s10_bits_q),
    .divisor_i (s10_d_q),
    .side_i    (s10_side_q),
    .valid_o   (kd_valid),
    .quot_o    (kd_quot),
    .side_o    (kd_side_raw)
  );

  assign kd_side = blsc_pkg::stf_side_t'(kd_side_raw);

  // Output register: sign, saturation and the invalid case.
  logic [31:0] k_mag;
  logic [31:0] k_val;

  always_comb begin
    if (kd_side.ksat) begin
      k_mag = kd_side.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      k_mag = {1'b0, kd_quot};
    end
    k_val = kd_side.neg ? (32'd0 - k_mag) : k_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= kd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    invalid_o        <= kd_side.inv;
    bond_length_o    <= kd_side.inv ? 20'd0 : kd_side.len;
    bond_stiffness_o <= kd_side.inv ? 32'sd0 : $signed(k_val);
    saturated_o      <= !kd_side.inv && (kd_side.sat || kd_side.ksat);
  end

  // An invalid result carries zeros in every other field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && invalid_o) |-> (bond_length_o == '0 && bond_stiffness_o == '0 && !saturated_o))
    else $error("invalid result with nonzero fields");

  // A valid result always has a nonzero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !invalid_o) |-> (bond_length_o != '0))
    else $error("zero length not flagged invalid");

  // The pipeline takes a pair in every cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

endmodule

`default_nettype wire

// File: hw/rtl/blsc_isqrt.sv
// Pipelined 32-bit integer square root, one result bit per stage.
`default_nettype none

module blsc_isqrt #(
  parameter int unsigned SW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [31:0]   value_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [15:0]        root_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned NSTEP = 16;

  logic          valid_q [NSTEP];
  logic [31:0]   v_q     [NSTEP];
  logic [31:0]   res_q   [NSTEP];
  logic [SW-1:0] side_q  [NSTEP];

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam logic [31:0] BIT = 32'(1) << (30 - 2 * k);
    logic          valid_prev;
    logic [31:0]   v_prev;
    logic [31:0]   res_prev;
    logic [SW-1:0] side_prev;
    logic [32:0]   trial;
    logic          ge;
    logic [31:0]   v_d;
    logic [31:0]   res_d;

    if (k == 0) begin : g_first
      assign valid_prev = valid_i;
      assign v_prev     = value_i;
      assign res_prev   = '0;
      assign side_prev  = side_i;
    end else begin : g_next
      assign valid_prev = valid_q[k-1];
      assign v_prev     = v_q[k-1];
      assign res_prev   = res_q[k-1];
      assign side_prev  = side_q[k-1];
    end

    assign trial = {1'b0, res_prev} + {1'b0, BIT};
    assign ge    = {1'b0, v_prev} >= trial;
    assign v_d   = ge ? (v_prev - trial[31:0]) : v_prev;
    assign res_d = ge ? ((res_prev >> 1) + BIT) : (res_prev >> 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      v_q[k]    <= v_d;
      res_q[k]  <= res_d;
      side_q[k] <= side_prev;
    end
  end

  assign valid_o = valid_q[NSTEP-1];
  assign root_o  = res_q[NSTEP-1][15:0];
  assign side_o  = side_q[NSTEP-1];

endmodule

`default_nettype wire

// File: hw/rtl/blsc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side record.
`default_nettype none

module blsc_div #(
  parameter int unsigned DW = 33,
  parameter int unsigned QW = 32,
  parameter int unsigned SW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [QW-1:0] bits_i,
  input  wire logic [DW-1:0] divisor_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [QW-1:0]      quot_o,
  output logic [SW-1:0]      side_o
);

  logic          valid_q [QW];
  logic [DW-1:0] rem_q   [QW];
  logic [QW-1:0] bits_q  [QW];
  logic [DW-1:0] dvs_q   [QW];
  logic [SW-1:0] side_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          valid_prev;
    logic [DW-1:0] rem_prev;
    logic [QW-1:0] bits_prev;
    logic [DW-1:0] dvs_prev;
    logic [SW-1:0] side_prev;
    logic [DW:0]   r2;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign valid_prev = valid_i;
      assign rem_prev   = rem_i;
      assign bits_prev  = bits_i;
      assign dvs_prev   = divisor_i;
      assign side_prev  = side_i;
    end else begin : g_next
      assign valid_prev = valid_q[k-1];
      assign rem_prev   = rem_q[k-1];
      assign bits_prev  = bits_q[k-1];
      assign dvs_prev   = dvs_q[k-1];
      assign side_prev  = side_q[k-1];
    end

    // The dividend bits leave at the top while quotient bits enter at the bottom.
    assign r2   = {rem_prev, bits_prev[QW-1]};
    assign diff = r2 - {1'b0, dvs_prev};
    assign ge   = r2 >= {1'b0, dvs_prev};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
      bits_q[k] <= {bits_prev[QW-2:0], ge};
      dvs_q[k]  <= dvs_prev;
      side_q[k] <= side_prev;
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quot_o  = bits_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire
